@@ rtl/tzr_pkg.sv @@
// Shared types, field widths and codes for the triangle depth-buffer rasteriser.
`timescale 1ns / 1ps
`default_nettype none
package tzr_pkg;

  // Screen size defaults
  localparam int DEF_WIDTH  = 128;
  localparam int DEF_HEIGHT = 128;

  // Item kinds
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;  // unused kind, does nothing

  // Field widths
  localparam int CW        = 11;  // screen coordinate 0..2047
  localparam int ADDR_MAXW = 22;  // pixel address for the largest screen
  localparam int QW        = 48;  // quotient and numerator of depth division
  localparam int DW        = 26;  // determinant magnitude and remainder
  localparam int UW        = 28;  // edge function values
  localparam int QDEPTH    = 2;   // command queue entries

  // Cleared pixel contents
  localparam logic [15:0] CLR_DEPTH = 16'hFFFF;
  localparam logic [31:0] CLR_COLOR = 32'h0000_00FF;
  localparam logic [14:0] CNT_MAX   = 15'h7FFF;

  // Classified command passed from the front end to the back end
  typedef struct packed {
    logic [1:0]              mode;
    logic                    box_empty;
    logic                    rd_ok;
    logic signed [11:0]      ax;
    logic signed [11:0]      ay;
    logic signed [15:0]      az;
    logic signed [12:0]      abx;
    logic signed [12:0]      aby;
    logic signed [16:0]      abz;
    logic signed [12:0]      acx;
    logic signed [12:0]      acy;
    logic signed [16:0]      acz;
    logic [CW-1:0]           x0;
    logic [CW-1:0]           x1;
    logic [CW-1:0]           y0;
    logic [CW-1:0]           y1;
    logic [ADDR_MAXW-1:0]    addr;
    logic [31:0]             color;
  } cmd_t;

  // Floor quotient with remainder
  typedef struct packed {
    logic signed [QW-1:0] q;
    logic [DW-1:0]        r;
  } qr_t;

endpackage
`default_nettype wire

@@ rtl/tzr_front.sv @@
// Front end: takes input transfers apart and classifies them into commands.
`timescale 1ns / 1ps
`default_nettype none
module tzr_front #(
  parameter int WIDTH  = tzr_pkg::DEF_WIDTH,
  parameter int HEIGHT = tzr_pkg::DEF_HEIGHT
) (
  input  wire logic [1:0]   mode,
  input  wire logic [151:0] data,
  output tzr_pkg::cmd_t     cmd
);

  localparam logic signed [12:0] XLIM = 13'(WIDTH - 1);
  localparam logic signed [12:0] YLIM = 13'(HEIGHT - 1);

  logic signed [11:0] ax, ay, bx, by_coord, cx, cy;
  logic signed [15:0] az, bz, cz;
  logic signed [11:0] xmin, xmax, ymin, ymax;
  logic signed [12:0] xmin_e, xmax_e, ymin_e, ymax_e, ax_e, ay_e;
  logic [tzr_pkg::CW-1:0] x0, x1, y0, y1, xx, yy;
  logic [23:0] addr_full;

  // Unpack fields
  assign ax       = data[11:0];
  assign ay       = data[23:12];
  assign az       = data[39:24];
  assign bx       = data[51:40];
  assign by_coord = data[63:52];
  assign bz       = data[79:64];
  assign cx       = data[91:80];
  assign cy       = data[103:92];
  assign cz       = data[119:104];

  // Bounding box
  always_comb begin
    xmin = ax;
    if (bx < xmin) xmin = bx;
    if (cx < xmin) xmin = cx;
    xmax = ax;
    if (bx > xmax) xmax = bx;
    if (cx > xmax) xmax = cx;
    ymin = ay;
    if (by_coord < ymin) ymin = by_coord;
    if (cy < ymin) ymin = cy;
    ymax = ay;
    if (by_coord > ymax) ymax = by_coord;
    if (cy > ymax) ymax = cy;
  end

  assign xmin_e = 13'(xmin);
  assign xmax_e = 13'(xmax);
  assign ymin_e = 13'(ymin);
  assign ymax_e = 13'(ymax);
  assign ax_e   = 13'(ax);
  assign ay_e   = 13'(ay);

  // Clip to the screen
  assign x0 = (xmin < 0) ? '0 : xmin[tzr_pkg::CW-1:0];
  assign y0 = (ymin < 0) ? '0 : ymin[tzr_pkg::CW-1:0];
  assign x1 = (xmax_e > XLIM) ? XLIM[tzr_pkg::CW-1:0] : xmax[tzr_pkg::CW-1:0];
  assign y1 = (ymax_e > YLIM) ? YLIM[tzr_pkg::CW-1:0] : ymax[tzr_pkg::CW-1:0];

  // Start pixel address: the read pixel, or the box corner for a draw
  assign xx = (mode == tzr_pkg::MODE_READ) ? ax[tzr_pkg::CW-1:0] : x0;
  assign yy = (mode == tzr_pkg::MODE_READ) ? ay[tzr_pkg::CW-1:0] : y0;
  assign addr_full = 24'(yy) * 24'(WIDTH) + 24'(xx);

  always_comb begin
    cmd.mode      = mode;
    cmd.box_empty = (xmax < 0) || (ymax < 0) || (xmin_e > XLIM) || (ymin_e > YLIM);
    cmd.rd_ok     = (ax >= 0) && (ax_e <= XLIM) && (ay >= 0) && (ay_e <= YLIM);
    cmd.ax        = ax;
    cmd.ay        = ay;
    cmd.az        = az;
    cmd.abx       = 13'(bx) - 13'(ax);
    cmd.aby       = 13'(by_coord) - 13'(ay);
    cmd.abz       = 17'(bz) - 17'(az);
    cmd.acx       = 13'(cx) - 13'(ax);
    cmd.acy       = 13'(cy) - 13'(ay);
    cmd.acz       = 17'(cz) - 17'(az);
    cmd.x0        = x0;
    cmd.x1        = x1;
    cmd.y0        = y0;
    cmd.y1        = y1;
    cmd.addr      = addr_full[tzr_pkg::ADDR_MAXW-1:0];
    cmd.color     = data[151:120];
  end

endmodule
`default_nettype wire

@@ rtl/tzr_fifo.sv @@
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module tzr_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  tzr_pkg::cmd_t      wr_cmd,
  input  wire logic          pop,
  output tzr_pkg::cmd_t      rd_cmd,
  output logic               full,
  output logic               not_empty
);

  localparam int QPW = (tzr_pkg::QDEPTH > 1) ? $clog2(tzr_pkg::QDEPTH) : 1;
  localparam int CNTW = $clog2(tzr_pkg::QDEPTH + 1);

  tzr_pkg::cmd_t entries [tzr_pkg::QDEPTH];
  logic [QPW-1:0]  wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;

  assign full      = (count == CNTW'(tzr_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign rd_cmd    = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(tzr_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(tzr_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_cmd;
  end

endmodule
`default_nettype wire

@@ rtl/tzr_div.sv @@
// Restoring divider, one quotient bit a cycle, floor quotient and remainder.
`timescale 1ns / 1ps
`default_nettype none
module tzr_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic signed [tzr_pkg::QW-1:0] num,
  input  wire logic [tzr_pkg::DW-1:0]      den,
  output logic                             busy,
  output logic                             done,
  output tzr_pkg::qr_t                     res
);

  localparam int QW = tzr_pkg::QW;
  localparam int DW = tzr_pkg::DW;
  localparam int NCW = $clog2(QW);

  logic [QW-1:0]  quo;
  logic [DW-1:0]  rem, den_r;
  logic [NCW-1:0] cnt;
  logic           neg, fix;
  logic [DW:0]    trial;
  logic           ge;

  assign trial = {rem, quo[QW-1]};
  assign ge    = (trial >= {1'b0, den_r});

  // Iterate on magnitudes, then fold the sign into floor form
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        neg   <= num[QW-1];
        quo   <= num[QW-1] ? QW'(-num) : QW'(num);
        rem   <= '0;
        den_r <= den;
      end else if (busy) begin
        rem <= ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        quo <= {quo[QW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == NCW'(QW - 1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
        if (neg && rem != '0) begin
          res.q <= -$signed(quo) - QW'(1);
          res.r <= den_r - rem;
        end else if (neg) begin
          res.q <= -$signed(quo);
          res.r <= '0;
        end else begin
          res.q <= $signed(quo);
          res.r <= rem;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/tzr_back.sv @@
// Back end: setup sequencer, pixel walk, depth and colour stores, result register.
`timescale 1ns / 1ps
`default_nettype none
module tzr_back #(
  parameter int WIDTH  = tzr_pkg::DEF_WIDTH,
  parameter int HEIGHT = tzr_pkg::DEF_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  tzr_pkg::cmd_t    cmd,
  input  wire logic        cmd_valid,
  output logic             cmd_pop,
  output logic             init_busy,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata
);

  localparam int NPIX = WIDTH * HEIGHT;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int QW   = tzr_pkg::QW;
  localparam int DW   = tzr_pkg::DW;
  localparam int UW   = tzr_pkg::UW;
  localparam int CW   = tzr_pkg::CW;

  typedef enum logic [13:0] {
    ST_CLR   = 14'b00000000000001,
    ST_IDLE  = 14'b00000000000010,
    ST_RD    = 14'b00000000000100,
    ST_RDD   = 14'b00000000001000,
    ST_MUL1  = 14'b00000000010000,
    ST_DET   = 14'b00000000100000,
    ST_SGN   = 14'b00000001000000,
    ST_MUL2  = 14'b00000010000000,
    ST_SUM   = 14'b00000100000000,
    ST_DGO   = 14'b00001000000000,
    ST_DWAIT = 14'b00010000000000,
    ST_PRD   = 14'b00100000000000,
    ST_PWR   = 14'b01000000000000,
    ST_RES   = 14'b10000000000000
  } state_t;

  state_t state;
  tzr_pkg::cmd_t c;
  logic init_r;

  // Stores
  logic [15:0] depth_mem [NPIX];
  logic [31:0] color_mem [NPIX];
  logic [15:0] rd_depth;
  logic [31:0] rd_color;
  logic        mem_we;
  logic [15:0] wr_depth;
  logic [31:0] wr_color;

  // Setup values
  logic signed [25:0] p_d1, p_d2;
  logic signed [29:0] p_n1, p_n2, p_n3, p_n4;
  logic signed [26:0] det;
  logic signed [30:0] nx_raw, ny_raw;
  logic [DW-1:0]      det_abs;
  logic signed [31:0] nx, ny;
  logic signed [13:0] du_dx, du_dy, dv_dx, dv_dy;
  logic signed [12:0] ox, oy;
  logic signed [26:0] p_u1, p_u2, p_v1, p_v2;
  logic signed [44:0] p_nn1, p_nn2;
  logic signed [UW-1:0] u0, v0;
  logic signed [QW-1:0] n0;
  tzr_pkg::qr_t q0, qx, qy;
  logic [1:0] div_idx;

  // Walk state
  logic signed [UW-1:0] u_cur, v_cur, u_row, v_row;
  tzr_pkg::qr_t qr_cur, qr_row, qr_xs, qr_ys, qr_ny;
  logic [AW-1:0] addr_cur, addr_row;
  logic [CW-1:0] x_cur, y_cur;
  logic [14:0]   cnt;

  // Results
  logic [31:0] res_color;
  logic [15:0] res_depth;

  // Divider
  logic div_start, div_busy, div_done;
  logic signed [QW-1:0] div_num;
  tzr_pkg::qr_t div_res;

  // Pixel test
  logic signed [QW-1:0] zq, z;
  logic signed [UW:0]   uv_sum;
  logic in_tri, pass, last_x, last_y;
  logic out_free;

  function automatic tzr_pkg::qr_t qr_add(tzr_pkg::qr_t a, tzr_pkg::qr_t b,
                                          logic [DW-1:0] d);
    logic [DW:0] s;
    tzr_pkg::qr_t o;
    s   = {1'b0, a.r} + {1'b0, b.r};
    o.q = a.q + b.q;
    o.r = s[DW-1:0];
    if (s >= {1'b0, d}) begin
      o.q = a.q + b.q + QW'(1);
      o.r = DW'(s - {1'b0, d});
    end
    return o;
  endfunction

  tzr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (det_abs),
    .busy  (div_busy),
    .done  (div_done),
    .res   (div_res)
  );

  assign init_busy = init_r;
  assign out_free  = !m_tvalid || m_tready;
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;
  assign div_start = (state == ST_DGO);

  always_comb begin
    case (div_idx)
      2'd0:    div_num = n0;
      2'd1:    div_num = QW'(nx);
      default: div_num = QW'(ny);
    endcase
  end

  // Inside and depth test for the current pixel
  assign uv_sum = (UW+1)'(u_cur) + (UW+1)'(v_cur);
  assign in_tri = !u_cur[UW-1] && !v_cur[UW-1] && (uv_sum <= $signed({3'b000, det_abs}));
  assign zq     = QW'(c.az) + qr_cur.q;
  assign z      = (zq < 0 && qr_cur.r != '0) ? zq + QW'(1) : zq;
  assign pass   = in_tri && (z > QW'($signed(rd_depth)));
  assign last_x = (x_cur == c.x1);
  assign last_y = (y_cur == c.y1);
  assign qr_xs  = qr_add(qr_cur, qx, det_abs);
  assign qr_ys  = qr_add(qr_row, qy, det_abs);
  assign qr_ny  = qr_ys;

  // Store writes
  always_comb begin
    mem_we   = 1'b0;
    wr_depth = tzr_pkg::CLR_DEPTH;
    wr_color = tzr_pkg::CLR_COLOR;
    if (state == ST_CLR) begin
      mem_we = 1'b1;
    end else if (state == ST_PWR && pass) begin
      mem_we   = 1'b1;
      wr_depth = z[15:0];
      wr_color = c.color;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[addr_cur] <= wr_depth;
      color_mem[addr_cur] <= wr_color;
    end
    rd_depth <= depth_mem[addr_cur];
    rd_color <= color_mem[addr_cur];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      init_r   <= 1'b1;
      addr_cur <= '0;
    end else begin
      case (state)
        ST_CLR: begin
          addr_cur <= addr_cur + 1'b1;
          if (addr_cur == AW'(NPIX - 1)) begin
            init_r <= 1'b0;
            state  <= init_r ? ST_IDLE : ST_RES;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            c         <= cmd;
            res_color <= '0;
            res_depth <= '0;
            cnt       <= '0;
            addr_cur  <= (cmd.mode == tzr_pkg::MODE_CLEAR) ? '0 : cmd.addr[AW-1:0];
            case (cmd.mode)
              tzr_pkg::MODE_CLEAR: state <= ST_CLR;
              tzr_pkg::MODE_DRAW: state <= cmd.box_empty ? ST_RES : ST_MUL1;
              tzr_pkg::MODE_READ: state <= cmd.rd_ok ? ST_RD : ST_RES;
              default:            state <= ST_RES;
            endcase
          end
        end
        ST_RD: state <= ST_RDD;
        ST_RDD: begin
          res_color <= rd_color;
          res_depth <= rd_depth;
          state     <= ST_RES;
        end
        ST_MUL1: begin
          p_d1  <= c.abx * c.acy;
          p_d2  <= c.acx * c.aby;
          p_n1  <= c.acy * c.abz;
          p_n2  <= c.aby * c.acz;
          p_n3  <= c.abx * c.acz;
          p_n4  <= c.acx * c.abz;
          state <= ST_DET;
        end
        ST_DET: begin
          det    <= 27'(p_d1) - 27'(p_d2);
          nx_raw <= 31'(p_n1) - 31'(p_n2);
          ny_raw <= 31'(p_n3) - 31'(p_n4);
          state  <= ST_SGN;
        end
        ST_SGN: begin
          // Orient the triangle so that the determinant is positive
          if (det == '0) begin
            state <= ST_RES;
          end else begin
            det_abs <= det[26] ? DW'(-det) : DW'(det);
            nx      <= det[26] ? -32'(nx_raw) : 32'(nx_raw);
            ny      <= det[26] ? -32'(ny_raw) : 32'(ny_raw);
            du_dx   <= det[26] ? -14'(c.acy) : 14'(c.acy);
            du_dy   <= det[26] ? 14'(c.acx) : -14'(c.acx);
            dv_dx   <= det[26] ? 14'(c.aby) : -14'(c.aby);
            dv_dy   <= det[26] ? -14'(c.abx) : 14'(c.abx);
            ox      <= $signed({2'b00, c.x0}) - 13'(c.ax);
            oy      <= $signed({2'b00, c.y0}) - 13'(c.ay);
            state   <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          p_u1  <= du_dx * ox;
          p_u2  <= du_dy * oy;
          p_v1  <= dv_dx * ox;
          p_v2  <= dv_dy * oy;
          p_nn1 <= nx * ox;
          p_nn2 <= ny * oy;
          state <= ST_SUM;
        end
        ST_SUM: begin
          u0      <= UW'(p_u1) + UW'(p_u2);
          v0      <= UW'(p_v1) + UW'(p_v2);
          n0      <= QW'(p_nn1) + QW'(p_nn2);
          div_idx <= 2'd0;
          state   <= ST_DGO;
        end
        ST_DGO: state <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            div_idx <= div_idx + 1'b1;
            case (div_idx)
              2'd0: begin
                q0    <= div_res;
                state <= ST_DGO;
              end
              2'd1: begin
                qx    <= div_res;
                state <= ST_DGO;
              end
              default: begin
                qy       <= div_res;
                u_cur    <= u0;
                v_cur    <= v0;
                u_row    <= u0;
                v_row    <= v0;
                qr_cur   <= q0;
                qr_row   <= q0;
                x_cur    <= c.x0;
                y_cur    <= c.y0;
                addr_row <= addr_cur;
                state    <= ST_PRD;
              end
            endcase
          end
        end
        ST_PRD: state <= ST_PWR;
        ST_PWR: begin
          if (pass && cnt != tzr_pkg::CNT_MAX) cnt <= cnt + 1'b1;
          if (last_x && last_y) begin
            state <= ST_RES;
          end else if (last_x) begin
            // Next row
            u_row    <= u_row + UW'(du_dy);
            v_row    <= v_row + UW'(dv_dy);
            u_cur    <= u_row + UW'(du_dy);
            v_cur    <= v_row + UW'(dv_dy);
            qr_row   <= qr_ys;
            qr_cur   <= qr_ny;
            addr_row <= addr_row + AW'(WIDTH);
            addr_cur <= addr_row + AW'(WIDTH);
            x_cur    <= c.x0;
            y_cur    <= y_cur + 1'b1;
            state    <= ST_PRD;
          end else begin
            u_cur    <= u_cur + UW'(du_dx);
            v_cur    <= v_cur + UW'(dv_dx);
            qr_cur   <= qr_xs;
            addr_cur <= addr_cur + 1'b1;
            x_cur    <= x_cur + 1'b1;
            state    <= ST_PRD;
          end
        end
        ST_RES: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_RES && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RES && out_free) m_tdata <= {1'b0, cnt, res_depth, res_color};
  end

  // Checks
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLR || state == ST_PWR))
    else $error("store written outside clear or pixel write");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PWR) |-> (qr_cur.r < det_abs))
    else $error("depth remainder out of range");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == ST_IDLE && !init_r))
    else $error("command taken while busy");
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule
`default_nettype wire

@@ rtl/triangle_zbuffer_rasterizer.sv @@
// Top level: triangle rasteriser with depth and colour stores.
//
// Input stream s_*: one transfer per command. tuser carries the mode (0 clear,
// 1 draw triangle, 2 read pixel, 3 does nothing); tdata carries vertices,
// depths and fill colour. Output stream m_*: exactly one result transfer per
// command, in order.
// Clear writes one store entry per cycle over all WIDTH*HEIGHT entries; a read
// takes one pixel from the stores; draw first runs its setup, with three
// divisions in the shared 48-step divider, then visits each pixel of the
// clipped bounding box with a read state and then a write state, since the
// single store port is read before it is written.
// Commands are handled one at a time; a two-entry queue lets new commands be
// taken while one is worked on.
// After reset the block clears both stores with s_tready low. When m_tready is
// low the finished result is held in the output register; the back end waits
// and the queue fills, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module triangle_zbuffer_rasterizer #(
  parameter int WIDTH  = tzr_pkg::DEF_WIDTH,
  parameter int HEIGHT = tzr_pkg::DEF_HEIGHT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz, fill_color
  input  wire logic [151:0] s_tdata,
  // mode
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pixel_color, pixel_depth, pixels_written, zero pad
  output logic [63:0]       m_tdata
);

  tzr_pkg::cmd_t new_cmd, q_cmd;
  logic q_full, q_not_empty, q_pop, init_busy, push;

  assign s_tready = !q_full && !init_busy;
  assign push     = s_tvalid && s_tready;

  tzr_front #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_front (
    .mode (s_tuser),
    .data (s_tdata),
    .cmd  (new_cmd)
  );

  tzr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_cmd    (new_cmd),
    .pop       (q_pop),
    .rd_cmd    (q_cmd),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  tzr_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .cmd_valid (q_not_empty),
    .cmd_pop   (q_pop),
    .init_busy (init_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire

@@ dv/triangle_zbuffer_rasterizer_tb.sv @@
// Triangle depth-buffer rasteriser bench: directed and random streams checked against a model.
`timescale 1ns / 1ps
module triangle_zbuffer_rasterizer_tb;
  import tzr_pkg::*;

  localparam int SW = 128;
  localparam int SH = 128;
  localparam int NPX = SW * SH;
  localparam int IDLE_LIMIT = 200000;

  typedef struct {
    logic [1:0] mode;
    logic signed [11:0] ax, ay, bx, by, cx, cy;
    logic signed [15:0] az, bz, cz;
    logic [31:0] col;
  } cmd_item_t;

  typedef struct {
    logic [31:0] col;
    logic [15:0] dep;
    logic [14:0] cnt;
  } pix_result_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [151:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [63:0] m_tdata;

  logic signed [15:0] depth_img[NPX];
  logic [31:0] color_img[NPX];
  pix_result_t pending_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit long_stall_mode = 0;

  triangle_zbuffer_rasterizer DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Mirror of the stores
  function automatic void clear_image();
    for (int k = 0; k < NPX; k++) begin
      depth_img[k] = -16'sd1;
      color_img[k] = CLR_COLOR;
    end
  endfunction

  function automatic pix_result_t predict_pixel_op(cmd_item_t c);
    pix_result_t r;
    longint abx, aby, abz, acx, acy, acz, det, sg, x0, x1, y0, y1, u, v, z, dx, dy;
    int idx, cnt;
    r = '{0, 0, 0};
    cnt = 0;
    case (c.mode)
      MODE_CLEAR: clear_image();
      MODE_READ: begin
        if (c.ax >= 0 && c.ax < SW && c.ay >= 0 && c.ay < SH) begin
          idx = c.ay * SW + c.ax;
          r.col = color_img[idx];
          r.dep = depth_img[idx];
        end
      end
      MODE_DRAW: begin
        abx = c.bx - c.ax; aby = c.by - c.ay; abz = c.bz - c.az;
        acx = c.cx - c.ax; acy = c.cy - c.ay; acz = c.cz - c.az;
        det = abx * acy - acx * aby;
        if (det != 0) begin
          sg = det < 0 ? -1 : 1;
          det = det * sg;
          x0 = c.ax; x1 = c.ax; y0 = c.ay; y1 = c.ay;
          if (c.bx < x0) x0 = c.bx;
          if (c.cx < x0) x0 = c.cx;
          if (c.bx > x1) x1 = c.bx;
          if (c.cx > x1) x1 = c.cx;
          if (c.by < y0) y0 = c.by;
          if (c.cy < y0) y0 = c.cy;
          if (c.by > y1) y1 = c.by;
          if (c.cy > y1) y1 = c.cy;
          if (x0 < 0) x0 = 0;
          if (y0 < 0) y0 = 0;
          if (x1 > SW - 1) x1 = SW - 1;
          if (y1 > SH - 1) y1 = SH - 1;
          for (longint y = y0; y <= y1; y++) begin
            for (longint x = x0; x <= x1; x++) begin
              dx = c.ax - x; dy = c.ay - y;
              u = sg * (acx * dy - acy * dx);
              v = sg * (aby * dx - abx * dy);
              if (u < 0 || v < 0 || u + v > det) continue;
              z = (c.az * det + u * abz + v * acz) / det;
              idx = 32'(y * SW + x);
              if (z > depth_img[idx]) begin
                depth_img[idx] = 16'(z);
                color_img[idx] = c.col;
                if (cnt < 32767) cnt++;
              end
            end
          end
        end
        r.cnt = 15'(cnt);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // Send one command, with a random gap first
  task automatic send_cmd(cmd_item_t c);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= c.mode;
    s_tdata <= {c.col, c.cz, c.cy, c.cx, c.bz, c.by, c.bx, c.az, c.ay, c.ax};
    do @(posedge clk); while (!s_tready);
    pending_q.push_back(predict_pixel_op(c));
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      pix_result_t w;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        w = pending_q.pop_front();
        if (m_tdata[31:0] !== w.col) report_mismatch("pixel_color", m_tdata[31:0], w.col);
        if (m_tdata[47:32] !== w.dep) report_mismatch("pixel_depth", m_tdata[47:32], w.dep);
        if (m_tdata[62:48] !== w.cnt) report_mismatch("pixels_written", m_tdata[62:48], w.cnt);
        if (m_tdata[63] !== 1'b0) report_mismatch("pad", m_tdata[63], 0);
      end
    end
  end

  // Output back-pressure: long stretches of stall in long-stall mode
  always @(posedge clk) begin
    if (long_stall_mode) m_tready <= ($urandom_range(0, 29) == 0);
    else m_tready <= $urandom_range(0, 3) != 0;
  end

  // Watchdog on accepted transfers
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("triangle_zbuffer_rasterizer_tb: FAIL");
      $finish;
    end
  end

  function automatic cmd_item_t mk(logic [1:0] m, int ax, int ay, int az, int bx, int by,
                                   int bz, int cx, int cy, int cz, logic [31:0] col);
    cmd_item_t c;
    c.mode = m; c.ax = 12'(ax); c.ay = 12'(ay); c.az = 16'(az);
    c.bx = 12'(bx); c.by = 12'(by); c.bz = 16'(bz);
    c.cx = 12'(cx); c.cy = 12'(cy); c.cz = 16'(cz); c.col = col;
    return c;
  endfunction

  function automatic cmd_item_t read_at(int x, int y);
    return mk(MODE_READ, x, y, 0, 0, 0, 0, 0, 0, 0, 0);
  endfunction

  // Directed: every mode and each special case
  task automatic test_directed();
    send_cmd(read_at(0, 0));
    send_cmd(read_at(127, 127));
    send_cmd(mk(MODE_DRAW, 10, 10, 100, 40, 12, 200, 15, 50, -300, 32'hFF00_00FF));
    send_cmd(read_at(20, 20));
    // same triangle again: equal depth writes nothing
    send_cmd(mk(MODE_DRAW, 10, 10, 100, 40, 12, 200, 15, 50, -300, 32'h00FF_00FF));
    // zero area
    send_cmd(mk(MODE_DRAW, 0, 0, 5, 10, 10, 5, 20, 20, 5, 32'h1234_5678));
    // box wholly off screen
    send_cmd(mk(MODE_DRAW, -2048, -2048, 32767, -1000, -2000, 32767, -1500, -10, 0, 32'hFFFF_FFFF));
    // extremes: the first lies off screen, the second covers the whole screen
    send_cmd(mk(MODE_DRAW, -2048, -2048, 32767, 2047, -2048, -32768, -2048, 2047, 32767,
                32'hFFFF_FFFF));
    send_cmd(mk(MODE_DRAW, 2047, 2047, -32768, -2048, 2047, 32767, 2047, -2048, -32768,
                32'hA5A5_5A5A));
    send_cmd(read_at(64, 64));
    send_cmd(read_at(-1, 5));
    send_cmd(read_at(5, 128));
    send_cmd(read_at(-2048, 2047));
    send_cmd(mk(MODE_NOP, 1, 1, 1, 50, 1, 1, 1, 50, 1, 32'hFFFF_FFFF));
    send_cmd(read_at(1, 1));
    send_cmd(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(read_at(64, 64));
  endtask

  // Random: mostly small on-screen triangles, interleaved reads
  task automatic test_random();
    cmd_item_t c;
    int r;
    for (int n = 0; n < 100; n++) begin
      long_stall_mode = (n % 25) > 18;
      r = $urandom_range(0, 99);
      c.ax = 12'($urandom); c.ay = 12'($urandom); c.az = 16'($urandom);
      c.bx = 12'($urandom); c.by = 12'($urandom); c.bz = 16'($urandom);
      c.cx = 12'($urandom); c.cy = 12'($urandom); c.cz = 16'($urandom);
      c.col = $urandom;
      if (r < 2) c.mode = MODE_CLEAR;
      else if (r < 4) c.mode = MODE_NOP;
      else if (r < 40) begin
        c.mode = MODE_READ;
        if ($urandom_range(0, 5) != 0) begin
          c.ax = 12'($urandom_range(0, SW - 1)); c.ay = 12'($urandom_range(0, SH - 1));
        end
      end else begin
        c.mode = MODE_DRAW;
        if ($urandom_range(0, 7) != 0) begin
          c.ax = 12'($urandom_range(0, 127) - 10); c.ay = 12'($urandom_range(0, 127) - 10);
          c.bx = 12'(c.ax + $urandom_range(0, 24) - 12);
          c.by = 12'(c.ay + $urandom_range(0, 24) - 12);
          c.cx = 12'(c.ax + $urandom_range(0, 24) - 12);
          c.cy = 12'(c.ay + $urandom_range(0, 24) - 12);
        end
      end
      send_cmd(c);
    end
    long_stall_mode = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    clear_image();
    test_directed();
    test_random();
    s_tvalid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("triangle_zbuffer_rasterizer_tb: PASS");
    else $display("triangle_zbuffer_rasterizer_tb: FAIL");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/tzr_pkg.sv
rtl/tzr_front.sv
rtl/tzr_fifo.sv
rtl/tzr_div.sv
rtl/tzr_back.sv
rtl/triangle_zbuffer_rasterizer.sv
dv/triangle_zbuffer_rasterizer_tb.sv
